// ===== rtl/b30_pkg.sv =====
// Package with shared types, constants and helpers of the base-30 field line wrapper.
`default_nettype none
package b30_pkg;

  localparam int unsigned ColW      = 7;
  localparam int unsigned MaxDigits = 7;
  localparam int unsigned DigCntW   = 3;

  // floor(n / 30) equals (n * Recip30) >> Recip30Shift for every 32-bit n.
  localparam logic [31:0] Recip30      = 32'h8888_8889;
  localparam int unsigned Recip30Shift = 36;
  localparam int unsigned QuotW        = 64 - Recip30Shift;
  localparam logic [31:0] Radix        = 32'd30;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_CR,
    ST_LF
  } b30_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_char;
    logic emit_cr;
    logic emit_lf;
  } b30_cmd_t;

  typedef struct packed {
    logic q_zero;
    logic out_free;
    logic wrap;
    logic is_final;
    logic all_sent;
  } b30_status_t;

  function automatic logic [7:0] b30_digit_char(input logic [4:0] r);
    logic [7:0] c;
    if (r < 5'd10) begin
      c = CharZero + {3'b000, r};
    end else begin
      c = CharA + {3'b000, r} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b30_in_if.sv =====
// Input channel interface: item kind, raw byte and signed integer.
`default_nettype none
interface b30_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         byte_value;
  logic signed [31:0] int_value;

  modport source (output valid, output func, output byte_value, output int_value,
                  input ready);
  modport sink (input valid, input func, input byte_value, input int_value,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/b30_out_if.sv =====
// Output channel interface: one character and its end-of-item flag.
`default_nettype none
interface b30_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/b30_ctrl.sv =====
// Controller state machine sequencing digit extraction, emission and line breaks.
`default_nettype none
module b30_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  output logic                in_ready_o,
  input  b30_pkg::b30_status_t status_i,
  output b30_pkg::b30_cmd_t    cmd_o
);

  b30_pkg::b30_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b30_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      b30_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_func_i ? b30_pkg::ST_MUL : b30_pkg::ST_EMIT;
        end
      end
      b30_pkg::ST_MUL: state_d = b30_pkg::ST_DIV;
      b30_pkg::ST_DIV: begin
        state_d = status_i.q_zero ? b30_pkg::ST_EMIT : b30_pkg::ST_MUL;
      end
      b30_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          if (status_i.wrap) begin
            state_d = b30_pkg::ST_CR;
          end else if (status_i.is_final) begin
            state_d = b30_pkg::ST_IDLE;
          end
        end
      end
      b30_pkg::ST_CR: begin
        if (status_i.out_free) begin
          state_d = b30_pkg::ST_LF;
        end
      end
      b30_pkg::ST_LF: begin
        if (status_i.out_free) begin
          state_d = status_i.all_sent ? b30_pkg::ST_IDLE : b30_pkg::ST_EMIT;
        end
      end
      default: state_d = b30_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      b30_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      b30_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      b30_pkg::ST_DIV:  cmd_o.div = 1'b1;
      b30_pkg::ST_EMIT: cmd_o.emit_char = status_i.out_free;
      b30_pkg::ST_CR:   cmd_o.emit_cr = status_i.out_free;
      b30_pkg::ST_LF:   cmd_o.emit_lf = status_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/b30_dp.sv =====
// Datapath: magnitude divider, digit stack, column counter and output register.
`default_nettype none
module b30_dp #(
  parameter int LINE_LENGTH = 80
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 func_i,
  input  logic [7:0]           byte_value_i,
  input  logic signed [31:0]   int_value_i,
  input  b30_pkg::b30_cmd_t    cmd_i,
  output b30_pkg::b30_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 last_o
);

  logic [31:0]                  mag_q;
  logic [b30_pkg::QuotW-1:0]    quot_q;
  logic [7:0]                   dig_q [b30_pkg::MaxDigits];
  logic [b30_pkg::DigCntW-1:0]  nd_q;
  logic                         neg_pend_q;
  logic                         end_pend_q;
  logic [7:0]                   end_char_q;
  logic [b30_pkg::ColW-1:0]     column_q;
  logic                         out_valid_q;
  logic [7:0]                   out_char_q;
  logic                         last_q;

  logic [63:0] prod;
  logic [31:0] rem_full;
  logic [7:0]  new_digit;
  logic [7:0]  col_inc;
  logic        wrap;
  logic        is_final;
  logic [7:0]  next_char;

  assign prod      = {32'd0, mag_q} * {32'd0, b30_pkg::Recip30};
  assign rem_full  = mag_q - ({{(32 - b30_pkg::QuotW){1'b0}}, quot_q} * b30_pkg::Radix);
  assign new_digit = b30_pkg::b30_digit_char(rem_full[4:0]);
  assign col_inc   = {1'b0, column_q} + 8'd1;
  assign wrap      = (col_inc >= 8'(LINE_LENGTH));
  assign is_final  = !neg_pend_q && (nd_q == '0);

  always_comb begin
    if (neg_pend_q) begin
      next_char = b30_pkg::CharMinus;
    end else if (nd_q != '0) begin
      next_char = dig_q[0];
    end else begin
      next_char = end_char_q;
    end
  end

  assign status_o.q_zero   = (quot_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.wrap     = wrap;
  assign status_o.is_final = is_final;
  assign status_o.all_sent = !end_pend_q;

  // Control state of the item in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q        <= '0;
      neg_pend_q  <= 1'b0;
      end_pend_q  <= 1'b0;
      column_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        nd_q       <= '0;
        neg_pend_q <= func_i & int_value_i[31];
        end_pend_q <= 1'b1;
      end else if (cmd_i.div) begin
        nd_q <= nd_q + 1'b1;
      end else if (cmd_i.emit_char) begin
        if (neg_pend_q) begin
          neg_pend_q <= 1'b0;
        end else if (nd_q != '0) begin
          nd_q <= nd_q - 1'b1;
        end else begin
          end_pend_q <= 1'b0;
        end
      end
      if (cmd_i.emit_char) begin
        column_q <= wrap ? '0 : col_inc[b30_pkg::ColW-1:0];
      end
      if (cmd_i.emit_char || cmd_i.emit_cr || cmd_i.emit_lf) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q      <= int_value_i[31] ? (~int_value_i + 32'd1) : int_value_i;
      end_char_q <= func_i ? b30_pkg::CharSlash : byte_value_i;
    end else if (cmd_i.div) begin
      mag_q <= {{(32 - b30_pkg::QuotW){1'b0}}, quot_q};
    end
    if (cmd_i.mul) begin
      quot_q <= prod[63:b30_pkg::Recip30Shift];
    end
    // Digits stack up with the most significant one on top.
    if (cmd_i.div) begin
      dig_q[0] <= new_digit;
      for (int i = 1; i < b30_pkg::MaxDigits; i++) begin
        dig_q[i] <= dig_q[i-1];
      end
    end else if (cmd_i.emit_char && !neg_pend_q && (nd_q != '0)) begin
      for (int i = 0; i < b30_pkg::MaxDigits - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
    if (cmd_i.emit_char) begin
      out_char_q <= next_char;
      last_q     <= is_final && !wrap;
    end else if (cmd_i.emit_cr) begin
      out_char_q <= b30_pkg::CharCr;
      last_q     <= 1'b0;
    end else if (cmd_i.emit_lf) begin
      out_char_q <= b30_pkg::CharLf;
      last_q     <= !end_pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

`ifndef SYNTH
  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    column_q < b30_pkg::ColW'(LINE_LENGTH))
    else $error("column counter reached the line length");

  a_wrap_restarts_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_char && wrap |=> column_q == '0)
    else $error("column counter did not restart after a full line");

  a_digit_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div |-> nd_q < b30_pkg::DigCntW'(b30_pkg::MaxDigits))
    else $error("digit stack overflow");

  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_cr |=> out_valid_q && out_char_q == b30_pkg::CharCr && !last_q)
    else $error("inserted carriage return not registered");
`endif

endmodule
`default_nettype wire

// ===== rtl/base30_field_line_wrapper.sv =====
// Top level of the base-30 field line wrapper: controller plus datapath.
`default_nettype none
// Sequence: a raw byte goes from the idle state to the emit state, which loads it into the output
//   register. An integer first alternates a multiply and a divide state per base-30 digit
//   (reciprocal multiply, then quotient and remainder), up to seven digits, before emission.
// Throughput: one item at a time; characters then leave one per cycle while the sink is ready.
// Reset: rst_ni is asynchronous, active low; it empties the output and zeroes the column.
module base30_field_line_wrapper #(
  parameter int LINE_LENGTH = 80
) (
  input logic        clk_i,
  input logic        rst_ni,
  b30_in_if.sink     in_i,
  b30_out_if.source  out_o
);

  // Commands from the controller and status back from the datapath.
  b30_pkg::b30_cmd_t    cmd;
  b30_pkg::b30_status_t status;

  // The controller owns the input handshake: a new item is taken only in its idle state,
  // after the previous item's last character has been loaded into the output register.
  b30_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath divides the magnitude by thirty with a reciprocal multiply, stacks the
  // digits, counts columns and holds the output register that decouples the sink.
  b30_dp #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (in_i.func),
    .byte_value_i (in_i.byte_value),
    .int_value_i  (in_i.int_value),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_char_o   (out_o.out_char),
    .last_o       (out_o.last)
  );

endmodule
`default_nettype wire
